/* sv/drt_pkg.sv */
package drt_pkg;

    localparam int TABLE_DEPTH_DEF = 16;
    localparam logic [31:0] LIFE_INFINITE = 32'hFFFF_FFFF;
    localparam logic [30:0] NEVER_EVENT = 31'h7FFF_FFFF;

    localparam logic CMD_ADD = 1'b0;
    localparam logic CMD_SWEEP = 1'b1;

    typedef struct packed {
        logic [63:0] addr_hi;
        logic [63:0] addr_lo;
        logic [1:0]  pref;
        logic [31:0] stamp;
        logic [31:0] life;
    } entry_t;

    // controller to datapath
    typedef struct packed {
        logic load;        // capture the input beat
        logic scan_clr;    // restart scan index at zero
        logic scan_inc;    // advance scan index
        logic rd;          // read entry at scan index
        logic wr_life;     // overwrite stamp and life at scan index
        logic shift_dn;    // move entry idx+1 to idx
        logic shift_up;    // move entry idx-1 to idx
        logic wr_new;      // write the captured entry at idx
        logic ret_hole;    // return index to the removed slot
        logic cnt_inc;
        logic cnt_dec;
        logic set_pos;     // record the insert position, set index to the count
        logic set_hole;    // remember the slot being removed
        logic note_exp;    // fold current expiry into the minimum
        logic set_changed;
        logic set_full;
        logic done;        // present the result
    } drt_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_sweep;
        logic life_zero;
        logic scan_end;    // scan index has reached the count
        logic hit;         // read entry matches the address
        logic pref_same;
        logic lower_pref;  // read entry less preferred than new one
        logic rd_inf;
        logic rd_expired;
        logic full;
        logic shift_end;   // shift index reached its end
    } drt_stat_t;

endpackage

/* sv/drt_ctrl.sv */
module drt_ctrl
    import drt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  drt_stat_t stat,
    output drt_cmd_t  cmd
);

    typedef enum logic [10:0] {
        S_IDLE    = 11'b00000000001,
        S_FIND_RD = 11'b00000000010,
        S_FIND    = 11'b00000000100,
        S_DROP    = 11'b00000001000,
        S_POS_RD  = 11'b00000010000,
        S_POS     = 11'b00000100000,
        S_OPEN    = 11'b00001000000,
        S_PUT     = 11'b00010000000,
        S_SW_RD   = 11'b00100000000,
        S_SW      = 11'b01000000000,
        S_DONE    = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;
    logic   sw_drop_reg, sw_drop_next;

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        sw_drop_next = sw_drop_reg;
        cmd = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    cmd.scan_clr = 1'b1;
                    state_next = S_FIND_RD;
                end
            end
            S_FIND_RD:
            begin
                if (stat.is_sweep)
                begin
                    state_next = S_SW_RD;
                end
                else if (stat.scan_end)
                begin
                    if (stat.life_zero)
                        state_next = S_DONE;
                    else
                    begin
                        cmd.scan_clr = 1'b1;
                        state_next = S_POS_RD;
                    end
                end
                else
                begin
                    cmd.rd = 1'b1;
                    state_next = S_FIND;
                end
            end
            S_FIND:
            begin
                if (stat.hit)
                begin
                    if (stat.life_zero)
                    begin
                        cmd.set_changed = 1'b1;
                        sw_drop_next = 1'b0;
                        state_next = S_DROP;
                    end
                    else if (!stat.pref_same)
                    begin
                        sw_drop_next = 1'b0;
                        state_next = S_DROP;
                    end
                    else
                    begin
                        cmd.wr_life = 1'b1;
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    cmd.scan_inc = 1'b1;
                    state_next = S_FIND_RD;
                end
            end
            S_DROP:
            begin
                // close the gap one entry per cycle
                if (stat.shift_end)
                begin
                    cmd.cnt_dec = 1'b1;
                    if (sw_drop_reg)
                    begin
                        // resume the sweep at the slot that now holds the next entry
                        cmd.ret_hole = 1'b1;
                        state_next = S_SW_RD;
                    end
                    else if (stat.life_zero)
                        state_next = S_DONE;
                    else
                    begin
                        cmd.scan_clr = 1'b1;
                        state_next = S_POS_RD;
                    end
                end
                else
                begin
                    cmd.shift_dn = 1'b1;
                end
            end
            S_POS_RD:
            begin
                if (stat.full)
                begin
                    cmd.set_full = 1'b1;
                    state_next = S_DONE;
                end
                else if (stat.scan_end)
                begin
                    cmd.set_pos = 1'b1;
                    state_next = S_OPEN;
                end
                else
                begin
                    cmd.rd = 1'b1;
                    state_next = S_POS;
                end
            end
            S_POS:
            begin
                if (stat.lower_pref)
                begin
                    cmd.set_pos = 1'b1;
                    state_next = S_OPEN;
                end
                else
                begin
                    cmd.scan_inc = 1'b1;
                    state_next = S_POS_RD;
                end
            end
            S_OPEN:
            begin
                if (stat.shift_end)
                    state_next = S_PUT;
                else
                    cmd.shift_up = 1'b1;
            end
            S_PUT:
            begin
                cmd.wr_new = 1'b1;
                cmd.cnt_inc = 1'b1;
                cmd.set_changed = 1'b1;
                state_next = S_DONE;
            end
            S_SW_RD:
            begin
                if (stat.scan_end)
                    state_next = S_DONE;
                else
                begin
                    cmd.rd = 1'b1;
                    state_next = S_SW;
                end
            end
            S_SW:
            begin
                if (stat.rd_inf)
                begin
                    cmd.scan_inc = 1'b1;
                    state_next = S_SW_RD;
                end
                else if (stat.rd_expired)
                begin
                    cmd.set_changed = 1'b1;
                    cmd.set_hole = 1'b1;
                    sw_drop_next = 1'b1;
                    state_next = S_DROP;
                end
                else
                begin
                    cmd.note_exp = 1'b1;
                    cmd.scan_inc = 1'b1;
                    state_next = S_SW_RD;
                end
            end
            S_DONE:
            begin
                cmd.done = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (state_reg == S_FIND && stat.hit && !stat.pref_same)
            cmd.set_hole = 1'b1;
        if (state_reg == S_FIND && stat.hit && stat.life_zero)
            cmd.set_hole = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sw_drop_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sw_drop_reg <= sw_drop_next;
        end
    end

endmodule

/* sv/drt_dp.sv */
module drt_dp
    import drt_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  drt_cmd_t    cmd,
    output drt_stat_t   stat,
    input  logic        cmd_in,
    input  logic [63:0] router_addr_hi,
    input  logic [63:0] router_addr_lo,
    input  logic [1:0]  router_pref,
    input  logic [31:0] stamp,
    input  logic [31:0] life,
    input  logic [31:0] now_secs,
    output logic        changed,
    output logic [30:0] next_event,
    output logic        table_full,
    output logic        done
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    // single-port style memory, one read or one move per cycle
    entry_t mem [TABLE_DEPTH];

    entry_t      new_reg;
    logic        sweep_reg;
    logic [31:0] now_reg;
    entry_t      rd_reg;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] idx_reg;
    logic [CW-1:0] idx_next;
    logic [CW-1:0] ipos_reg;
    logic [CW-1:0] hole_reg;
    logic          opening_reg;
    logic        chg_reg;
    logic        full_reg;
    logic [30:0] min_reg;
    logic        done_reg;
    logic [32:0] rd_exp;
    logic [IW-1:0] a_cur;
    logic [IW-1:0] a_adj;
    logic [CW-1:0] adj;

    assign rd_exp = {1'b0, rd_reg.stamp} + {1'b0, rd_reg.life};
    assign a_cur = idx_reg[IW-1:0];
    // neighbor for shifting: idx+1 when closing, idx-1 when opening
    assign adj = cmd.shift_up ? idx_reg - CW'(1) : idx_reg + CW'(1);
    assign a_adj = adj[IW-1:0];

    assign stat.is_sweep = sweep_reg;
    assign stat.life_zero = (new_reg.life == '0);
    assign stat.scan_end = (idx_reg >= cnt_reg);
    assign stat.hit = (rd_reg.addr_hi == new_reg.addr_hi) &&
                      (rd_reg.addr_lo == new_reg.addr_lo);
    assign stat.pref_same = (rd_reg.pref == new_reg.pref);
    assign stat.lower_pref = (rd_reg.pref < new_reg.pref);
    assign stat.rd_inf = (rd_reg.life == LIFE_INFINITE);
    assign stat.rd_expired = ({1'b0, now_reg} >= rd_exp);
    assign stat.full = (cnt_reg >= DEPTH_C);
    // opening stops at the insert position; closing stops at count-1
    assign stat.shift_end = opening_reg ? (idx_reg == ipos_reg)
                                        : ((idx_reg + CW'(1)) >= cnt_reg);

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.scan_clr)
            idx_next = '0;
        else if (cmd.scan_inc)
            idx_next = idx_reg + CW'(1);
        else if (cmd.shift_dn)
            idx_next = idx_reg + CW'(1);
        else if (cmd.shift_up)
            idx_next = idx_reg - CW'(1);
        else if (cmd.set_pos)
            idx_next = cnt_reg;
        else if (cmd.ret_hole)
            idx_next = hole_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd)
            rd_reg <= mem[a_cur];
        if (cmd.load)
        begin
            new_reg.addr_hi <= router_addr_hi;
            new_reg.addr_lo <= router_addr_lo;
            new_reg.pref <= router_pref;
            new_reg.stamp <= stamp;
            new_reg.life <= life;
            now_reg <= now_secs;
        end
        if (cmd.wr_life)
        begin
            mem[a_cur].stamp <= new_reg.stamp;
            mem[a_cur].life <= new_reg.life;
        end
        else if (cmd.shift_dn || cmd.shift_up)
            mem[a_cur] <= mem[a_adj];
        else if (cmd.wr_new)
            mem[a_cur] <= new_reg;
        if (cmd.set_pos)
            ipos_reg <= stat.scan_end ? cnt_reg : idx_reg;
        if (cmd.set_hole)
            hole_reg <= idx_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_reg <= 1'b0;
            cnt_reg <= '0;
            idx_reg <= '0;
            chg_reg <= 1'b0;
            full_reg <= 1'b0;
            min_reg <= NEVER_EVENT;
            done_reg <= 1'b0;
            opening_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.done;
            idx_reg <= idx_next;
            if (cmd.load)
            begin
                sweep_reg <= cmd_in;
                chg_reg <= 1'b0;
                full_reg <= 1'b0;
                min_reg <= NEVER_EVENT;
            end
            if (cmd.set_changed)
                chg_reg <= 1'b1;
            if (cmd.set_full)
                full_reg <= 1'b1;
            if (cmd.cnt_inc)
                cnt_reg <= cnt_reg + CW'(1);
            else if (cmd.cnt_dec)
                cnt_reg <= cnt_reg - CW'(1);
            if (cmd.note_exp && ({2'b0, min_reg} > rd_exp))
                min_reg <= rd_exp[30:0];
            if (cmd.set_pos)
                opening_reg <= 1'b1;
            else if (cmd.done)
                opening_reg <= 1'b0;
        end
    end

    assign changed = chg_reg;
    assign next_event = min_reg;
    assign table_full = full_reg;
    assign done = done_reg;

endmodule

/* sv/default_router_table.sv */
// Preference-ordered IPv6 default router table, TABLE_DEPTH entries.
// Pulse start while busy is low; the result appears on changed,
// next_event and table_full for one cycle with done high and cannot be
// stalled, so sample it then. An add scans the entries for the address;
// a match is updated in place, or removed by shifting the later entries
// down. If the new life is not zero, it then scans for the insert position,
// shifts the entries from the end up to that position up one slot and
// writes the new entry. A sweep scans every entry and, for each expired
// entry, shifts the entries after it down one slot. The entry memory
// serves one read or one move per cycle, and the scans and every shift
// step go through that port.
module default_router_table
    import drt_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        cmd,
    input  logic [63:0] router_addr_hi,
    input  logic [63:0] router_addr_lo,
    input  logic [1:0]  router_pref,
    input  logic [31:0] stamp,
    input  logic [31:0] life,
    input  logic [31:0] now_secs,
    output logic        done,
    output logic        changed,
    output logic [30:0] next_event,
    output logic        table_full
);

    drt_cmd_t  ctl;
    drt_stat_t st;

    drt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (st),
        .cmd   (ctl)
    );

    drt_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (ctl),
        .stat           (st),
        .cmd_in         (cmd),
        .router_addr_hi (router_addr_hi),
        .router_addr_lo (router_addr_lo),
        .router_pref    (router_pref),
        .stamp          (stamp),
        .life           (life),
        .now_secs       (now_secs),
        .changed        (changed),
        .next_event     (next_event),
        .table_full     (table_full),
        .done           (done)
    );

endmodule

/* sv/drt_checker.sv */
module drt_checker
    import drt_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic        changed,
    input logic [30:0] next_event,
    input logic        table_full
);

    // an accepted beat makes the block busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("beat accepted without going busy");

    // the result strobe ends the item
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while still busy");

    // no result without an item in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("done without a busy item");

    // full and changed never both report
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(table_full && changed))
        else $error("full drop reported as change");

    // a full drop comes from an add, which reports no expiry
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && table_full) |-> (next_event == NEVER_EVENT))
        else $error("full drop with an expiry");

endmodule

bind default_router_table drt_checker u_drt_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .changed    (changed),
    .next_event (next_event),
    .table_full (table_full)
);

/* tb/default_router_table_tb.sv */
module default_router_table_tb
    import drt_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = TABLE_DEPTH_DEF;
    localparam int RANDOM_ITEMS = 750;

    typedef struct {
        logic        cmd;
        logic [63:0] addr_hi;
        logic [63:0] addr_lo;
        logic [1:0]  pref;
        logic [31:0] stamp;
        logic [31:0] life;
        logic [31:0] now;
    } router_beat_t;

    typedef struct {
        logic        changed;
        logic [30:0] next_event;
        logic        table_full;
    } table_reply_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        cmd;
    logic [63:0] router_addr_hi;
    logic [63:0] router_addr_lo;
    logic [1:0]  router_pref;
    logic [31:0] stamp;
    logic [31:0] life;
    logic [31:0] now_secs;
    logic        done;
    logic        changed;
    logic [30:0] next_event;
    logic        table_full;

    router_beat_t pending_beats[$];
    table_reply_t expected_replies[$];
    int error_count = 0;
    int reply_count = 0;
    int add_count = 0;
    int sweep_count = 0;
    int full_count = 0;
    bit stimulus_done = 0;

    // shadow copy of the router table
    entry_t shadow[DEPTH];
    int     shadow_count = 0;

    // small pool of addresses so updates and removals hit existing entries
    logic [63:0] pool_hi[24];
    logic [63:0] pool_lo[24];

    default_router_table dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .cmd(cmd),
        .router_addr_hi(router_addr_hi),
        .router_addr_lo(router_addr_lo),
        .router_pref(router_pref),
        .stamp(stamp),
        .life(life),
        .now_secs(now_secs),
        .done(done),
        .changed(changed),
        .next_event(next_event),
        .table_full(table_full)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic void remove_at(input int k);
        for (int j = k; j + 1 < shadow_count; j++)
            shadow[j] = shadow[j + 1];
        shadow_count--;
    endfunction

    function automatic table_reply_t apply_router_beat(input router_beat_t b);
        table_reply_t r;
        int k;
        int pos;
        bit handled;
        logic [32:0] expiry;
        r.changed = 1'b0;
        r.next_event = NEVER_EVENT;
        r.table_full = 1'b0;
        handled = 0;
        if (b.cmd == CMD_ADD)
        begin
            add_count++;
            for (k = 0; k < shadow_count; k++)
                if (shadow[k].addr_hi == b.addr_hi && shadow[k].addr_lo == b.addr_lo)
                    break;
            if (k < shadow_count)
            begin
                if (b.life == 0)
                begin
                    remove_at(k);
                    r.changed = 1'b1;
                    handled = 1;
                end
                else if (shadow[k].pref != b.pref)
                    remove_at(k);
                else
                begin
                    shadow[k].stamp = b.stamp;
                    shadow[k].life = b.life;
                    handled = 1;
                end
            end
            if (!handled && b.life != 0)
            begin
                pos = shadow_count;
                for (k = 0; k < shadow_count; k++)
                    if (shadow[k].pref < b.pref)
                    begin
                        pos = k;
                        break;
                    end
                if (shadow_count >= DEPTH)
                begin
                    r.table_full = 1'b1;
                    full_count++;
                end
                else
                begin
                    for (int j = shadow_count; j > pos; j--)
                        shadow[j] = shadow[j - 1];
                    shadow[pos].addr_hi = b.addr_hi;
                    shadow[pos].addr_lo = b.addr_lo;
                    shadow[pos].pref = b.pref;
                    shadow[pos].stamp = b.stamp;
                    shadow[pos].life = b.life;
                    shadow_count++;
                    r.changed = 1'b1;
                end
            end
        end
        else
        begin
            sweep_count++;
            k = 0;
            while (k < shadow_count)
            begin
                expiry = {1'b0, shadow[k].stamp} + {1'b0, shadow[k].life};
                if (shadow[k].life == LIFE_INFINITE)
                    k++;
                else if ({1'b0, b.now} >= expiry)
                begin
                    remove_at(k);
                    r.changed = 1'b1;
                end
                else
                begin
                    if ({2'b0, r.next_event} > expiry)
                        r.next_event = expiry[30:0];
                    k++;
                end
            end
        end
        return r;
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 5))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(0, 200);
            3: return 32'h7FFF_FF00 + $urandom_range(0, 511);
            default: return $urandom;
        endcase
    endfunction

    function automatic router_beat_t add_beat(input int slot, input logic [1:0] pref,
                                               input logic [31:0] st, input logic [31:0] lf);
        router_beat_t b;
        b.cmd = CMD_ADD;
        b.addr_hi = pool_hi[slot];
        b.addr_lo = pool_lo[slot];
        b.pref = pref;
        b.stamp = st;
        b.life = lf;
        b.now = $urandom;
        return b;
    endfunction

    function automatic router_beat_t sweep_beat(input logic [31:0] now);
        router_beat_t b;
        b.cmd = CMD_SWEEP;
        b.addr_hi = {$urandom, $urandom};
        b.addr_lo = {$urandom, $urandom};
        b.pref = 2'($urandom_range(0, 3));
        b.stamp = $urandom;
        b.life = $urandom;
        b.now = now;
        return b;
    endfunction

    // driver: one beat per pending item, random gap after each
    int gap_left = 0;
    always @(negedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else if (start)
            ;
        else if (gap_left > 0)
            gap_left <= gap_left - 1;
        else if (pending_beats.size() > 0)
        begin
            router_beat_t b;
            b = pending_beats.pop_front();
            start <= 1'b1;
            cmd <= b.cmd;
            router_addr_hi <= b.addr_hi;
            router_addr_lo <= b.addr_lo;
            router_pref <= b.pref;
            stamp <= b.stamp;
            life <= b.life;
            now_secs <= b.now;
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
        end
    end

    // acceptance and result checking at the rising edge
    bit drop_start = 0;
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
        begin
            router_beat_t b;
            b.cmd = cmd;
            b.addr_hi = router_addr_hi;
            b.addr_lo = router_addr_lo;
            b.pref = router_pref;
            b.stamp = stamp;
            b.life = life;
            b.now = now_secs;
            expected_replies.push_back(apply_router_beat(b));
            drop_start = 1;
        end
        if (rst_n && done)
        begin
            table_reply_t e;
            reply_count++;
            if (expected_replies.size() == 0)
            begin
                $display("%t: unexpected result changed=%0d next_event=%0d table_full=%0d",
                         $realtime, changed, next_event, table_full);
                error_count++;
            end
            else
            begin
                e = expected_replies.pop_front();
                if (changed !== e.changed)
                begin
                    $display("%t: changed expected %0d actual %0d", $realtime,
                             e.changed, changed);
                    error_count++;
                end
                if (next_event !== e.next_event)
                begin
                    $display("%t: next_event expected %0d actual %0d", $realtime,
                             e.next_event, next_event);
                    error_count++;
                end
                if (table_full !== e.table_full)
                begin
                    $display("%t: table_full expected %0d actual %0d", $realtime,
                             e.table_full, table_full);
                    error_count++;
                end
            end
        end
    end

    // lower start at the falling edge after the beat was taken
    always @(negedge clk)
    begin
        if (drop_start)
        begin
            drop_start = 0;
            start <= 1'b0;
        end
    end

    initial
    begin
        int slot;
        logic [1:0] p;
        logic [31:0] now;
        rst_n = 1'b0;
        start = 1'b0;
        cmd = CMD_ADD;
        router_addr_hi = '0;
        router_addr_lo = '0;
        router_pref = '0;
        stamp = '0;
        life = '0;
        now_secs = '0;
        for (int i = 0; i < 24; i++)
        begin
            pool_hi[i] = {$urandom, $urandom};
            pool_lo[i] = {$urandom, $urandom};
        end
        pool_hi[0] = '0;
        pool_lo[0] = '0;
        pool_hi[1] = '1;
        pool_lo[1] = '1;
        pool_hi[2] = '0;
        pool_lo[2] = '1;

        // directed: empty sweep, preference ordering, updates, removal, full table
        pending_beats.push_back(sweep_beat(32'h0));
        pending_beats.push_back(add_beat(2, 2'd0, 32'd0, 32'd0));
        pending_beats.push_back(add_beat(0, 2'd1, 32'd10, 32'd20));
        pending_beats.push_back(add_beat(1, 2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        pending_beats.push_back(add_beat(2, 2'd0, 32'd5, 32'd100));
        pending_beats.push_back(add_beat(3, 2'd2, 32'h7FFF_FFF0, 32'h20));
        pending_beats.push_back(add_beat(0, 2'd1, 32'd15, 32'd40));
        pending_beats.push_back(add_beat(0, 2'd3, 32'd15, 32'd40));
        pending_beats.push_back(add_beat(4, 2'd1, 32'hFFFF_FFFF, 32'd3));
        pending_beats.push_back(sweep_beat(32'd30));
        pending_beats.push_back(sweep_beat(32'd200));
        pending_beats.push_back(add_beat(3, 2'd2, 32'd1, 32'd0));
        for (int i = 5; i < 19; i++)
            pending_beats.push_back(add_beat(i, 2'(i % 4), 32'(i * 7), 32'h1000));
        pending_beats.push_back(add_beat(20, 2'd3, 32'd1, 32'd1));
        pending_beats.push_back(sweep_beat(32'hFFFF_FFFF));

        // random: mostly adds from the pool, with sweeps and some fresh addresses
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                now = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 400) : pick_word();
                pending_beats.push_back(sweep_beat(now));
            end
            else
            begin
                slot = $urandom_range(0, 23);
                p = 2'($urandom_range(0, 3));
                pending_beats.push_back(add_beat(slot, p,
                    ($urandom_range(0, 1) == 0) ? $urandom_range(0, 300) : pick_word(),
                    ($urandom_range(0, 7) == 0) ? 32'h0 :
                    ($urandom_range(0, 1) == 0) ? $urandom_range(1, 300) : pick_word()));
                if ($urandom_range(0, 9) == 0)
                begin
                    pending_beats[$].addr_hi = {$urandom, $urandom};
                    pending_beats[$].addr_lo = {$urandom, $urandom};
                end
            end
        end

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (pending_beats.size() == 0 && !start);
        stimulus_done = 1;
        wait (expected_replies.size() == 0);
        repeat (4 * DEPTH + 20) @(posedge clk);
        $display("Ran %0d adds and %0d sweeps, %0d results checked, %0d full-table drops.",
                 add_count, sweep_count, reply_count, full_count);
        if (error_count == 0 && expected_replies.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #10ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule

/* sim.f */
sv/drt_pkg.sv
sv/drt_ctrl.sv
sv/drt_dp.sv
sv/default_router_table.sv
sv/drt_checker.sv
tb/default_router_table_tb.sv
